>>> rtl/float_to_pcm_sample_converter_macros.svh
// assertion macros for the sample converter
`ifndef FLOAT_TO_PCM_SAMPLE_CONVERTER_MACROS_SVH
`define FLOAT_TO_PCM_SAMPLE_CONVERTER_MACROS_SVH

// implication checked on every clock edge outside reset
`define F2P_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// plain condition checked at every clock edge, reset included
`define F2P_ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

>>> rtl/f2p_pkg.sv
`default_nettype none
package f2p_pkg;

  localparam logic [1:0] FMT_F32 = 2'd0;
  localparam logic [1:0] FMT_S8  = 2'd1;
  localparam logic [1:0] FMT_S16 = 2'd2;
  localparam logic [1:0] FMT_S32 = 2'd3;

  localparam logic [2:0] BYTES_F32 = 3'd4;
  localparam logic [2:0] BYTES_S8  = 3'd1;
  localparam logic [2:0] BYTES_S16 = 3'd2;
  localparam logic [2:0] BYTES_S32 = 3'd4;

  // sideband that travels with each item through the pipe
  typedef struct packed {
    logic       valid;
    logic [1:0] fmt;
    logic       block_end;
  } ctl_t;

  function automatic logic [2:0] bytes_for(input logic [1:0] fmt);
    logic [2:0] b;
    unique case (fmt)
      FMT_S8:  b = BYTES_S8;
      FMT_S16: b = BYTES_S16;
      FMT_S32: b = BYTES_S32;
      default: b = BYTES_F32;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/f2p_scale.sv
`default_nettype none
// clamp, exact integer product, then float rounding to 24 bits and truncation
module f2p_scale (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire f2p_pkg::ctl_t    ctl_i,
  input  wire logic [31:0]      bits_i,
  output f2p_pkg::ctl_t         ctl_o,
  output logic [31:0]           word_o
);
  import f2p_pkg::*;

  // ---- stage 1: decode and clamp to a 24-bit mantissa with exponent
  ctl_t        ctl1_q;
  logic [31:0] raw1_q;
  logic        sgn1_q, one1_q, zero1_q;
  logic [23:0] man1_q;
  logic [4:0]  sh1_q;       // value = man * 2^-(sh+23) ; sh in 1..31 else zero

  logic        sgn_d, one_d, zero_d;
  logic [23:0] man_d;
  logic [4:0]  sh_d;
  logic [7:0]  e;

  always_comb begin
    e      = bits_i[30:23];
    sgn_d  = bits_i[31];
    one_d  = 1'b0;
    zero_d = 1'b0;
    man_d  = {1'b1, bits_i[22:0]};
    sh_d   = 5'd1;
    if (e == 8'hff && bits_i[22:0] != 23'd0) begin
      sgn_d = 1'b0; one_d = 1'b1;
    end else if (e >= 8'd127) begin
      one_d = 1'b1;
    end else if (e < 8'd96) begin
      zero_d = 1'b1;   // below 2^-31: every product truncates to zero
    end else begin
      sh_d = 5'(8'd127 - e);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    raw1_q  <= bits_i;
    sgn1_q  <= sgn_d;
    one1_q  <= one_d;
    zero1_q <= zero_d;
    man1_q  <= man_d;
    sh1_q   <= sh_d;
  end

  // ---- stage 2: multiply mantissa by the integer scale
  logic [15:0] scl;
  always_comb begin
    unique case (ctl1_q.fmt)
      FMT_S8:  scl = 16'd127;
      FMT_S16: scl = 16'd32767;
      default: scl = 16'd1;
    endcase
  end

  ctl_t        ctl2_q;
  logic [31:0] raw2_q;
  logic        sgn2_q, one2_q, zero2_q;
  logic [39:0] prod2_q;
  logic [4:0]  sh2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw2_q  <= raw1_q;
    sgn2_q  <= sgn1_q;
    one2_q  <= one1_q;
    zero2_q <= zero1_q;
    prod2_q <= man1_q * scl;
    sh2_q   <= sh1_q;
  end

  // ---- stage 3: round product to 24 significant bits (rne), keep int part
  // product value = prod * 2^-(sh+23); rounding only matters for s8/s16
  logic [39:0] rnd;
  logic [5:0]  lead;
  logic [5:0]  drop;
  logic [39:0] half, mask, low;
  logic [40:0] up;
  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 40; i++) begin
      if (prod2_q[i]) lead = 6'(i);
    end
    drop = (lead > 6'd23) ? 6'(lead - 6'd23) : 6'd0;
    mask = (40'd1 << drop) - 40'd1;
    half = (drop == 6'd0) ? 40'd0 : (40'd1 << (drop - 6'd1));
    low  = prod2_q & mask;
    up   = {1'b0, prod2_q & ~mask};
    if (drop != 6'd0 && (low > half ||
        (low == half && prod2_q[drop]))) begin
      up = up + (41'd1 << drop);
    end
    rnd = up[39:0];
  end

  ctl_t        ctl3_q;
  logic [31:0] raw3_q;
  logic        sgn3_q, one3_q, zero3_q;
  logic [39:0] rnd3_q;
  logic [4:0]  sh3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw3_q  <= raw2_q;
    sgn3_q  <= sgn2_q;
    one3_q  <= one2_q;
    zero3_q <= zero2_q;
    rnd3_q  <= rnd;
    sh3_q   <= sh2_q;
  end

  // ---- stage 4: shift to integer, apply sign and saturation
  logic [39:0] mag40;
  logic [31:0] mag, sres, word_d;
  always_comb begin
    if (ctl3_q.fmt == FMT_S32) begin
      // times 2^31 is exact: value = man * 2^(8-sh)
      mag40 = (sh3_q <= 5'd8) ? (rnd3_q << (5'd8 - sh3_q))
                              : (rnd3_q >> (sh3_q - 5'd8));
    end else begin
      mag40 = rnd3_q >> (6'(sh3_q) + 6'd23);
    end
    mag = mag40[31:0];
    if (zero3_q) mag = 32'd0;
    unique case (ctl3_q.fmt)
      FMT_S8:  if (one3_q) mag = 32'd127;
      FMT_S16: if (one3_q) mag = 32'd32767;
      default: if (one3_q) mag = 32'h8000_0000;
    endcase
    sres = sgn3_q ? (32'd0 - mag) : mag;
    if (ctl3_q.fmt == FMT_S32 && !sgn3_q && mag[31]) sres = 32'h7fff_ffff;
    word_d = (ctl3_q.fmt == FMT_F32) ? raw3_q : sres;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_o <= word_d;
  end

endmodule
`default_nettype wire

>>> rtl/float_to_pcm_sample_converter.sv
`default_nettype none
// float32 to pcm converter, four register stages
// a result strobes on done_o once its start transfer has passed the four register stages
// throughput: one sample per cycle, busy is always low and the receiver cannot stall
// reset: asynchronous active low, clears the valid pipe and sets format to float32
// format writes are taken at any time; ready is always high
module float_to_pcm_sample_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] sample_bits_i,
  input  wire logic        block_end_in_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,
  output logic             done_o,
  output logic [31:0]      pcm_word_o,
  output logic [2:0]       sample_bytes_o,
  output logic             block_end_out_o
);
  import f2p_pkg::*;

  logic [1:0] fmt_q;
  ctl_t       ctl_in, ctl_out;

  // no back pressure anywhere: the pipe always moves
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_F32;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // format is captured per item so it travels with the sample
  assign ctl_in = '{valid: start, fmt: fmt_q, block_end: block_end_in_i};

  f2p_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_in),
    .bits_i (sample_bits_i),
    .ctl_o  (ctl_out),
    .word_o (pcm_word_o)
  );

  assign done_o          = ctl_out.valid;
  assign sample_bytes_o  = bytes_for(ctl_out.fmt);
  assign block_end_out_o = ctl_out.block_end;

endmodule
`default_nettype wire

>>> rtl/f2p_checker.sv
`default_nettype none
`include "float_to_pcm_sample_converter_macros.svh"
module f2p_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [2:0]  sample_bytes_o
);
  `F2P_ASSERT_ALWAYS(a_never_busy, clk_i, !busy, "busy raised")
  `F2P_ASSERT_IMPL(a_latency, clk_i, rst_ni, (start |-> ##4 done_o), "result missing")
  `F2P_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, (done_o |-> $past(start, 4)), "spurious result")
  `F2P_ASSERT_IMPL(a_bytes, clk_i, rst_ni,
    (done_o |-> (sample_bytes_o == 3'd1 || sample_bytes_o == 3'd2 || sample_bytes_o == 3'd4)),
    "bad byte count")
endmodule

bind float_to_pcm_sample_converter f2p_checker u_f2p_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .sample_bytes_o (sample_bytes_o)
);
`default_nettype wire

>>> verif/tb_float_to_pcm_sample_converter.sv
`timescale 1ns / 100ps
module tb_float_to_pcm_sample_converter;
  import f2p_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 8;   // pipe is four stages deep

  // one expected pcm result
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        blk_end;
  } pcm_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] sample_bits_i = '0;
  logic        block_end_in_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = FMT_F32;
  logic        done_o;
  logic [31:0] pcm_word_o;
  logic [2:0]  sample_bytes_o;
  logic        block_end_out_o;

  pcm_result_t pending_pcm[$];
  logic [1:0]  cur_fmt = FMT_F32;   // format the converter holds
  int          mismatches = 0;
  int          idle_cycles = 0;

  float_to_pcm_sample_converter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_bits_i  (sample_bits_i),
    .block_end_in_i (block_end_in_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .pcm_word_o     (pcm_word_o),
    .sample_bytes_o (sample_bytes_o),
    .block_end_out_o(block_end_out_o)
  );

  always #10 clk_i = ~clk_i;

  // bit-exact float to pcm: clamp, single precision multiply with
  // round-to-nearest-even, then truncate toward zero
  function automatic logic [31:0] pcm_from_float(input logic [31:0] b, input logic [1:0] fmt);
    logic [7:0]  ex;
    logic [63:0] mant, scale, prod, q, rem, half, mag;
    logic        neg;
    int          e, msb, sh;
    if (fmt == FMT_F32) return b;
    ex  = b[30:23];
    neg = b[31];
    if (ex == 8'hFF && b[22:0] != '0) begin
      // nan of either sign counts as full scale positive
      neg = 1'b0; mant = 64'd1 << 23; e = -23;
    end else if (ex >= 8'd127) begin
      // magnitude at or beyond one, infinities too
      mant = 64'd1 << 23; e = -23;
    end else if (ex == 8'd0) begin
      mant = {41'd0, b[22:0]}; e = -149;
    end else begin
      mant = {40'd0, 1'b1, b[22:0]}; e = int'(ex) - 150;
    end
    case (fmt)
      FMT_S8:  scale = 64'd127;
      FMT_S16: scale = 64'd32767;
      default: scale = 64'd2147483648;  // 2147483647.0f rounds up to 2^31
    endcase
    prod = mant * scale;
    if (prod != '0) begin
      msb = 63;
      while (!prod[msb]) msb--;
      if (msb > 23) begin
        // keep 24 significant bits
        sh   = msb - 23;
        half = 64'd1 << (sh - 1);
        rem  = prod & ((64'd1 << sh) - 64'd1);
        q    = prod >> sh;
        if (rem > half || (rem == half && q[0])) q++;
        prod = q << sh;
      end
    end
    if (e >= 0) mag = prod << e;
    else if (-e >= 64) mag = '0;
    else mag = prod >> (-e);
    if (!neg && mag >= 64'd2147483648) mag = 64'd2147483647;
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic logic [2:0] bytes_of_format(input logic [1:0] fmt);
    case (fmt)
      FMT_S8:  return BYTES_S8;
      FMT_S16: return BYTES_S16;
      FMT_S32: return BYTES_S32;
      default: return BYTES_F32;
    endcase
  endfunction

  // drive one sample and hold it until the start transfer; start stays high
  task automatic send_sample(input logic [31:0] bits, input logic blk_end);
    pcm_result_t exp_pcm;
    start          <= 1'b1;
    sample_bits_i  <= bits;
    block_end_in_i <= blk_end;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_pcm.word    = pcm_from_float(bits, cur_fmt);
    exp_pcm.nbytes  = bytes_of_format(cur_fmt);
    exp_pcm.blk_end = blk_end;
    pending_pcm.push_back(exp_pcm);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender waits for every outstanding pcm word
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk_i);
  endtask

  // format changes only with the pipe empty
  task automatic write_format(input logic [1:0] fmt);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_fmt = fmt;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1: r = {r[31], 8'($urandom_range(96, 126)), r[22:0]};   // in range audio
      2:    r = {r[31], 8'($urandom_range(126, 128)), r[22:0]};  // around full scale
      3: begin
        // specials: infinities, nans, zeros, denormals
        case ($urandom_range(0, 3))
          0: r = {r[31], 8'hFF, 23'd0};
          1: r = {r[31], 8'hFF, r[22:1], 1'b1};
          2: r = {r[31], 31'd0};
          default: r = {r[31], 8'd0, r[22:0]};
        endcase
      end
      default: ;  // any bit pattern
    endcase
    return r;
  endfunction

  // extremes and special cases under every format
  task automatic test_directed();
    write_format(FMT_F32);
    send_sample(32'h7FC0_0001, 1'b0);  // nan passes through untouched
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0001, 1'b1);
    send_sample(32'h3F80_0000, 1'b0);
    send_sample(32'hFF80_0000, 1'b1);
    write_format(FMT_S8);
    send_sample(32'h3F80_0000, 1'b1);  // full scale positive
    send_sample(32'hBF80_0000, 1'b0);  // full scale negative
    send_sample(32'h7FC0_0000, 1'b1);  // nan as plus one
    send_sample(32'hFF80_0000, 1'b0);  // minus infinity clamps
    send_sample(32'h8000_0000, 1'b1);  // negative zero
    send_sample(32'h4000_0000, 1'b0);  // out of range
    write_format(FMT_S16);
    send_sample(32'h7F80_0000, 1'b0);
    send_sample(32'hC000_0000, 1'b1);
    send_sample(32'h3F00_0000, 1'b0);  // one half, product is exact and the fraction truncates
    send_sample(32'h0000_0001, 1'b1);  // smallest denormal
    send_sample(32'hFFFF_FFFF, 1'b0);  // negative nan
    send_sample(32'h3F7F_FFFF, 1'b1);
    write_format(FMT_S32);
    send_sample(32'h3F80_0000, 1'b0);  // saturates to max positive
    send_sample(32'hBF80_0000, 1'b1);  // exact min negative
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h3F7F_FFFF, 1'b1);
    send_sample(32'hBF7F_FFFF, 1'b0);
    send_sample(32'h3000_0000, 1'b1);
    hold_off(0);
  endtask

  // random samples in bursts with random gaps, one drain in the middle
  task automatic test_random_format(input logic [1:0] fmt, input int count);
    int sent, burst;
    write_format(fmt);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_sample(rand_sample(), 1'($urandom_range(0, 1)));
        sent++;
        if (sent == count / 2) wait_drained();
      end
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
    end
    hold_off(0);
  endtask

  // result checker: done_o strobes for one cycle and cannot be held off
  always @(posedge clk_i) begin
    pcm_result_t exp_pcm;
    if (rst_ni && done_o) begin
      if (pending_pcm.size() == 0) begin
        $display("%0t: unexpected result word=%h", $time, pcm_word_o);
        mismatches++;
      end else begin
        exp_pcm = pending_pcm.pop_front();
        if (pcm_word_o !== exp_pcm.word) begin
          $display("%0t: pcm_word expected %h actual %h", $time, exp_pcm.word, pcm_word_o);
          mismatches++;
        end
        if (sample_bytes_o !== exp_pcm.nbytes) begin
          $display("%0t: sample_bytes expected %0d actual %0d", $time, exp_pcm.nbytes,
                   sample_bytes_o);
          mismatches++;
        end
        if (block_end_out_o !== exp_pcm.blk_end) begin
          $display("%0t: block_end expected %b actual %b", $time, exp_pcm.blk_end,
                   block_end_out_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_format(FMT_S8, 120);
    test_random_format(FMT_S16, 120);
    test_random_format(FMT_S32, 140);
    test_random_format(FMT_F32, 100);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_pcm.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
